/* rtl/dpsm_pkg.sv */
// Shared types, codes and constants of the drive profile state master.
`default_nettype none

package dpsm_pkg;

	localparam int unsigned RETRY_ATTEMPTS_DEF = 10;
	localparam int unsigned RETRY_W = 4;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef logic [2:0]         drv_state_t;
	typedef logic [1:0]         cmd_t;
	typedef logic [RETRY_W-1:0] retry_t;
	typedef logic [WORD_W-1:0]  word_t;

	// Drive state codes.
	localparam drv_state_t ST_NOT_READY        = 3'd0;
	localparam drv_state_t ST_SWITCH_ON_DIS    = 3'd1;
	localparam drv_state_t ST_READY            = 3'd2;
	localparam drv_state_t ST_SWITCHED_ON      = 3'd3;
	localparam drv_state_t ST_OP_ENABLED       = 3'd4;
	localparam drv_state_t ST_QUICK_STOP       = 3'd5;
	localparam drv_state_t ST_FAULT_REACTION   = 3'd6;
	localparam drv_state_t ST_FAULT            = 3'd7;

	// Item commands.
	localparam cmd_t CMD_STATUS   = 2'd0;
	localparam cmd_t CMD_REQUEST  = 2'd1;
	localparam cmd_t CMD_READBACK = 2'd2;
	localparam cmd_t CMD_HALT     = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_RUNNING   = 2'd0;
	localparam logic [1:0] REG_MODE_BITS = 2'd1;
	localparam logic [1:0] REG_QS_OPTION = 2'd2;

	// Control word fields.
	localparam word_t LOW_MASK    = 16'h008F;
	localparam word_t MODE_MASK   = 16'h0270;
	localparam word_t HALT_BIT    = 16'h0100;
	localparam word_t FAULT_RESET = 16'h0080;

	// Low control bits for each transition.
	localparam word_t CW_DISABLE_VOLTAGE = 16'h0000;
	localparam word_t CW_QUICK_STOP      = 16'h0002;
	localparam word_t CW_SHUTDOWN        = 16'h0006;
	localparam word_t CW_SWITCH_ON       = 16'h0007;
	localparam word_t CW_ENABLE_OP       = 16'h000F;

	// Status word decode masks and patterns.
	localparam word_t SW_MASK_A      = 16'h004F;
	localparam word_t SW_MASK_B      = 16'h006F;
	localparam word_t SW_NOT_READY   = 16'h0000;
	localparam word_t SW_SO_DISABLED = 16'h0040;
	localparam word_t SW_READY       = 16'h0021;
	localparam word_t SW_SWITCHED_ON = 16'h0023;
	localparam word_t SW_OP_ENABLED  = 16'h0027;
	localparam word_t SW_QUICK_STOP  = 16'h0007;
	localparam word_t SW_FAULT_REACT = 16'h000F;
	localparam word_t SW_FAULT       = 16'h0008;

	typedef struct packed {
		logic  running;
		word_t mode_bits;
		logic signed [WORD_W-1:0] qs_option;
	} cfg_t;

	typedef struct packed {
		drv_state_t cur;
		drv_state_t tgt;
		logic       pending;
		retry_t     retries;
		word_t      ctrl;
	} state_t;

	typedef struct packed {
		cmd_t       command;
		word_t      status_word;
		drv_state_t requested_state;
		word_t      readback_word;
		logic       node_started;
	} item_t;

	typedef struct packed {
		logic       write_valid;
		word_t      control_word;
		drv_state_t drive_state;
		logic       state_changed;
		logic       halt_changed;
		logic       halt_active;
	} result_t;

endpackage

`default_nettype wire

/* rtl/dpsm_apb_regs.sv */
// APB-style configuration registers of the drive profile state master.
`default_nettype none

module dpsm_apb_regs
	import dpsm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RUNNING:   cfg_q.running   <= pwdata[0];
				REG_MODE_BITS: cfg_q.mode_bits <= pwdata[WORD_W-1:0];
				REG_QS_OPTION: cfg_q.qs_option <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_RUNNING:   prdata[0]          = cfg_q.running;
			REG_MODE_BITS: prdata[WORD_W-1:0] = cfg_q.mode_bits;
			REG_QS_OPTION: prdata[WORD_W-1:0] = cfg_q.qs_option;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/dpsm_decode.sv */
// Status word to drive state decoder.
`default_nettype none

module dpsm_decode
	import dpsm_pkg::*;
(
	input  wire word_t      status_word,
	output drv_state_t      state
);

	word_t m1;
	word_t m2;

	assign m1 = status_word & SW_MASK_A;
	assign m2 = status_word & SW_MASK_B;

	// Patterns are tried in order; anything unmatched reads as not ready.
	always_comb begin
		priority if (m1 == SW_NOT_READY)   state = ST_NOT_READY;
		else if (m1 == SW_SO_DISABLED)     state = ST_SWITCH_ON_DIS;
		else if (m2 == SW_READY)           state = ST_READY;
		else if (m2 == SW_SWITCHED_ON)     state = ST_SWITCHED_ON;
		else if (m2 == SW_OP_ENABLED)      state = ST_OP_ENABLED;
		else if (m2 == SW_QUICK_STOP)      state = ST_QUICK_STOP;
		else if (m1 == SW_FAULT_REACT)     state = ST_FAULT_REACTION;
		else if (m1 == SW_FAULT)           state = ST_FAULT;
		else                               state = ST_NOT_READY;
	end

endmodule

`default_nettype wire

/* rtl/dpsm_core.sv */
// Next-state and result logic for one item of the drive profile state master.
`default_nettype none

module dpsm_core
	import dpsm_pkg::*;
#(
	parameter int unsigned RETRY_ATTEMPTS = RETRY_ATTEMPTS_DEF
) (
	input  wire cfg_t   cfg,
	input  wire state_t st,
	input  wire item_t  item,
	output state_t      st_next,
	output result_t     res
);

	typedef struct packed {
		word_t cw;
		logic  tgt_one;
	} step_t;

	localparam retry_t RETRY_RELOAD = retry_t'(RETRY_ATTEMPTS);

	function automatic word_t set_low(input word_t cw, input word_t bits);
		return (cw & ~LOW_MASK) | bits;
	endfunction

	function automatic step_t step_toward(input drv_state_t cur, input drv_state_t goal,
			input word_t cw_in, input cfg_t c);
		step_t r;
		word_t cw;
		cw = cw_in;
		r.tgt_one = 1'b0;
		if (cur != ST_NOT_READY)
			cw = (cw & ~MODE_MASK) | (c.mode_bits & MODE_MASK);
		unique case (cur)
			ST_NOT_READY, ST_SWITCH_ON_DIS: begin
				if (goal == ST_READY || goal == ST_OP_ENABLED) cw = set_low(cw, CW_SHUTDOWN);
			end
			ST_READY: begin
				if (goal == ST_SWITCH_ON_DIS) cw = set_low(cw, CW_DISABLE_VOLTAGE);
				else if (goal == ST_SWITCHED_ON || goal == ST_OP_ENABLED)
					cw = set_low(cw, CW_SWITCH_ON);
			end
			ST_SWITCHED_ON: begin
				if (goal == ST_OP_ENABLED) cw = set_low(cw, CW_ENABLE_OP);
				else if (goal == ST_READY) cw = set_low(cw, CW_SHUTDOWN);
				else if (goal == ST_SWITCH_ON_DIS) cw = set_low(cw, CW_DISABLE_VOLTAGE);
			end
			ST_OP_ENABLED: begin
				if (goal == ST_SWITCH_ON_DIS) cw = set_low(cw, CW_DISABLE_VOLTAGE);
				else if (goal == ST_READY) cw = set_low(cw, CW_SHUTDOWN);
				else if (goal == ST_SWITCHED_ON) cw = set_low(cw, CW_SWITCH_ON);
				else if (goal == ST_QUICK_STOP) begin
					cw = set_low(cw, CW_QUICK_STOP);
					// Quick stop options 1 and 2 end in switch-on-disabled.
					r.tgt_one = (c.qs_option == 16'sd1) || (c.qs_option == 16'sd2);
				end
			end
			ST_QUICK_STOP: begin
				if (goal == ST_SWITCH_ON_DIS || goal == ST_OP_ENABLED)
					cw = set_low(cw, CW_DISABLE_VOLTAGE);
			end
			ST_FAULT: begin
				if (goal != ST_NOT_READY) cw = set_low(cw, FAULT_RESET);
			end
			default: ;
		endcase
		r.cw = cw & ~HALT_BIT;
		return r;
	endfunction

	drv_state_t dec_state;
	logic       fault_clr;
	word_t      ctrl_fc;
	logic       run_ok;
	step_t      stp_status;
	step_t      stp_req;
	logic       wr;
	word_t      word;

	dpsm_decode u_decode (
		.status_word (item.status_word),
		.state       (dec_state)
	);

	assign run_ok    = cfg.running && item.node_started;
	assign fault_clr = (dec_state == ST_SWITCH_ON_DIS) && ((st.ctrl & LOW_MASK) == FAULT_RESET);
	assign ctrl_fc   = fault_clr ? (st.ctrl & ~FAULT_RESET) : st.ctrl;

	assign stp_status = step_toward(dec_state, st.tgt, ctrl_fc, cfg);
	assign stp_req    = step_toward(st.cur, item.requested_state, st.ctrl, cfg);

	always_comb begin
		st_next           = st;
		wr                = 1'b0;
		word              = '0;
		res.state_changed = 1'b0;
		res.halt_changed  = 1'b0;
		unique case (item.command)
			CMD_STATUS: begin
				st_next.cur       = dec_state;
				res.state_changed = (dec_state != st.cur);
				if (fault_clr) begin
					st_next.ctrl = ctrl_fc;
					wr           = 1'b1;
					word         = ctrl_fc;
				end
				if (st.pending && st.tgt != dec_state) begin
					// A retry on the same word overrides the fault reset clear.
					if (run_ok) begin
						st_next.ctrl = stp_status.cw;
						wr           = 1'b1;
						word         = stp_status.cw;
						if (stp_status.tgt_one) st_next.tgt = ST_SWITCH_ON_DIS;
					end
					if (st.retries <= retry_t'(1)) begin
						st_next.pending = 1'b0;
						st_next.tgt     = dec_state;
						st_next.retries = RETRY_RELOAD;
					end else begin
						st_next.retries = st.retries - retry_t'(1);
					end
				end else begin
					st_next.pending = 1'b0;
					st_next.tgt     = dec_state;
					st_next.retries = RETRY_RELOAD;
				end
			end
			CMD_REQUEST: begin
				if (run_ok) begin
					st_next.pending = 1'b1;
					st_next.tgt     = stp_req.tgt_one ? ST_SWITCH_ON_DIS : item.requested_state;
					st_next.ctrl    = stp_req.cw;
					wr              = 1'b1;
					word            = stp_req.cw;
				end
			end
			CMD_READBACK: begin
				res.halt_changed = |((st.ctrl ^ item.readback_word) & HALT_BIT);
				st_next.ctrl     = item.readback_word;
			end
			CMD_HALT: begin
				if (cfg.running && st.cur == ST_OP_ENABLED) begin
					wr   = 1'b1;
					word = st.ctrl ^ HALT_BIT;
				end
			end
			default: ;
		endcase
		res.write_valid  = wr;
		res.control_word = word;
		res.drive_state  = st_next.cur;
		res.halt_active  = st_next.ctrl[8];
	end

endmodule

`default_nettype wire

/* rtl/drive_profile_state_master.sv */
// Drive profile state master: input register, item logic, result register.
// Items are taken into the input register, results into the result register.
// One item per cycle when not stalled; the state update is one pass of dpsm_core.
// The input register takes one item while a result waits under stall.
// Reset clears the configuration, the drive state, the pending request, the stored
// control word, and reloads the retry counter; no clearing pass is needed.
`default_nettype none

module drive_profile_state_master
	import dpsm_pkg::*;
#(
	parameter int unsigned RETRY_ATTEMPTS = RETRY_ATTEMPTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        command,
	input  wire logic [15:0]       status_word,
	input  wire logic [2:0]        requested_state,
	input  wire logic [15:0]       readback_word,
	input  wire logic              node_started,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   write_valid,
	output logic [15:0]            control_word,
	output logic [2:0]             drive_state,
	output logic                   state_changed,
	output logic                   halt_changed,
	output logic                   halt_active
);

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    in_take;

	dpsm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dpsm_core #(
		.RETRY_ATTEMPTS (RETRY_ATTEMPTS)
	) u_core (
		.cfg     (cfg),
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res)
	);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.command         <= command;
			item_s1.status_word     <= status_word;
			item_s1.requested_state <= requested_state;
			item_s1.readback_word   <= readback_word;
			item_s1.node_started    <= node_started;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cur     <= ST_NOT_READY;
			state_q.tgt     <= ST_NOT_READY;
			state_q.pending <= 1'b0;
			state_q.retries <= retry_t'(RETRY_ATTEMPTS);
			state_q.ctrl    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign write_valid   = res_q.write_valid;
	assign control_word  = res_q.control_word;
	assign drive_state   = res_q.drive_state;
	assign state_changed = res_q.state_changed;
	assign halt_changed  = res_q.halt_changed;
	assign halt_active   = res_q.halt_active;

endmodule

`default_nettype wire
